// ----- design/rae_pkg.sv -----
// ----------------------------------------------------------------------------
// rae_pkg: shared definitions for the register ALU executor
// Word and register file sizes, opcodes, microcode fields and the
// read-only control program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rae_pkg;

	localparam int WORD_WIDTH    = 16;
	localparam int REG_COUNT     = 8;
	localparam int CMD_W         = 5;
	localparam int TGT_W         = 3;
	localparam int RF_IDX_W      = $clog2(REG_COUNT);
	localparam int DIV_CNT_W     = $clog2(WORD_WIDTH);

	// Opcodes
	localparam logic [CMD_W-1:0] OP_SET = CMD_W'(1);
	localparam logic [CMD_W-1:0] OP_ADD = CMD_W'(2);
	localparam logic [CMD_W-1:0] OP_SUB = CMD_W'(3);
	localparam logic [CMD_W-1:0] OP_MUL = CMD_W'(4);
	localparam logic [CMD_W-1:0] OP_MLI = CMD_W'(5);
	localparam logic [CMD_W-1:0] OP_DIV = CMD_W'(6);
	localparam logic [CMD_W-1:0] OP_DVI = CMD_W'(7);

	// Datapath actions
	localparam int DP_W = 4;
	localparam logic [DP_W-1:0] DP_NONE    = 4'd0;
	localparam logic [DP_W-1:0] DP_SET     = 4'd1;
	localparam logic [DP_W-1:0] DP_ADD     = 4'd2;
	localparam logic [DP_W-1:0] DP_SUB     = 4'd3;
	localparam logic [DP_W-1:0] DP_MUL     = 4'd4;
	localparam logic [DP_W-1:0] DP_MUL_WB  = 4'd5;
	localparam logic [DP_W-1:0] DP_DIV_INI = 4'd6;
	localparam logic [DP_W-1:0] DP_DIV_STP = 4'd7;
	localparam logic [DP_W-1:0] DP_DIV_WB  = 4'd8;
	localparam logic [DP_W-1:0] DP_FAULT   = 4'd9;
	localparam logic [DP_W-1:0] DP_REPORT  = 4'd10;

	// Sequencer branch kinds
	localparam int JMP_W = 3;
	localparam logic [JMP_W-1:0] J_NEXT     = 3'd0;
	localparam logic [JMP_W-1:0] J_GOTO     = 3'd1;
	localparam logic [JMP_W-1:0] J_ACCEPT   = 3'd2;
	localparam logic [JMP_W-1:0] J_DISPATCH = 3'd3;
	localparam logic [JMP_W-1:0] J_IF_ZERO  = 3'd4;
	localparam logic [JMP_W-1:0] J_LOOP     = 3'd5;
	localparam logic [JMP_W-1:0] J_REPORT   = 3'd6;

	// Program addresses
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] U_IDLE    = 4'd0;
	localparam logic [UPC_W-1:0] U_DECODE  = 4'd1;
	localparam logic [UPC_W-1:0] U_SET     = 4'd2;
	localparam logic [UPC_W-1:0] U_ADD     = 4'd3;
	localparam logic [UPC_W-1:0] U_SUB     = 4'd4;
	localparam logic [UPC_W-1:0] U_MUL     = 4'd5;
	localparam logic [UPC_W-1:0] U_MUL_WB  = 4'd6;
	localparam logic [UPC_W-1:0] U_DIV_INI = 4'd7;
	localparam logic [UPC_W-1:0] U_DIV_STP = 4'd8;
	localparam logic [UPC_W-1:0] U_DIV_WB  = 4'd9;
	localparam logic [UPC_W-1:0] U_FAULT   = 4'd10;
	localparam logic [UPC_W-1:0] U_NOP     = 4'd11;
	localparam logic [UPC_W-1:0] U_REPORT  = 4'd12;

	typedef struct packed {
		logic [DP_W-1:0]  dp;
		logic [JMP_W-1:0] jmp;
		logic [UPC_W-1:0] tgt;
	} ctl_word_t;

	typedef struct packed {
		logic div_last;
		logic opnd_zero;
	} dp_stat_t;

	function automatic ctl_word_t ucode(input logic [UPC_W-1:0] addr);
		ctl_word_t cw;
		unique case (addr)
			U_IDLE:    cw = '{DP_NONE,    J_ACCEPT,   U_DECODE};
			U_DECODE:  cw = '{DP_NONE,    J_DISPATCH, U_IDLE};
			U_SET:     cw = '{DP_SET,     J_GOTO,     U_REPORT};
			U_ADD:     cw = '{DP_ADD,     J_GOTO,     U_REPORT};
			U_SUB:     cw = '{DP_SUB,     J_GOTO,     U_REPORT};
			U_MUL:     cw = '{DP_MUL,     J_NEXT,     U_IDLE};
			U_MUL_WB:  cw = '{DP_MUL_WB,  J_GOTO,     U_REPORT};
			U_DIV_INI: cw = '{DP_DIV_INI, J_IF_ZERO,  U_REPORT};
			U_DIV_STP: cw = '{DP_DIV_STP, J_LOOP,     U_DIV_STP};
			U_DIV_WB:  cw = '{DP_DIV_WB,  J_GOTO,     U_REPORT};
			U_FAULT:   cw = '{DP_FAULT,   J_GOTO,     U_REPORT};
			U_NOP:     cw = '{DP_NONE,    J_GOTO,     U_REPORT};
			U_REPORT:  cw = '{DP_REPORT,  J_REPORT,   U_IDLE};
			default:   cw = '{DP_NONE,    J_GOTO,     U_IDLE};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// ----- design/register_alu_executor.sv -----
// ----------------------------------------------------------------------------
// register_alu_executor: microcoded arithmetic core on eight 16-bit words
// Runs SET, ADD, SUB, MUL and DIV on a register file and an excess word,
// faulting and halting on an unknown opcode.
// ----------------------------------------------------------------------------
// Steps: an item is accepted in the idle step and decoded; SET, ADD, SUB,
//   no-ops, faults and divide by zero then take one action step, MUL a
//   multiply and a write-back step, DIV an init step, the restoring divider
//   loop (one quotient bit per cycle) and a write-back step; then the report.
// One item at a time, taken in the idle step; a result still waiting holds the report.
// Reset: arst_n clears registers, excess, flags, halt and the sequencer.
`default_nettype none

module register_alu_executor (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [rae_pkg::CMD_W-1:0]          command,
	input  wire logic [rae_pkg::TGT_W-1:0]          target_register,
	input  wire logic [rae_pkg::WORD_WIDTH-1:0]     operand_value,
	// output channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [rae_pkg::TGT_W-1:0]          written_register,
	output logic      [rae_pkg::WORD_WIDTH-1:0]     register_value,
	output logic      [rae_pkg::WORD_WIDTH-1:0]     excess_value,
	output logic                                    overflow_flag,
	output logic                                    underflow_flag,
	output logic                                    fault,
	output logic                                    halted
);

	// Sequencer
	logic [rae_pkg::UPC_W-1:0]       upc_q;
	logic [rae_pkg::UPC_W-1:0]       upc_d;
	logic [rae_pkg::UPC_W-1:0]       upc_inc;
	logic [rae_pkg::UPC_W-1:0]       disp_addr;
	rae_pkg::ctl_word_t              cw;

	// Latched instruction and machine status
	logic [rae_pkg::CMD_W-1:0]       cmd_q;
	logic [rae_pkg::TGT_W-1:0]       tgt_q;
	logic [rae_pkg::WORD_WIDTH-1:0]  opnd_q;
	logic                            halted_q;
	logic                            fault_q;

	// Output register
	logic                            out_valid_q;
	logic [rae_pkg::TGT_W-1:0]       out_tgt_q;
	logic [rae_pkg::WORD_WIDTH-1:0]  out_reg_q;
	logic [rae_pkg::WORD_WIDTH-1:0]  out_exc_q;
	logic                            out_ovf_q;
	logic                            out_unf_q;
	logic                            out_fault_q;
	logic                            out_halted_q;

	// Datapath view
	rae_pkg::dp_stat_t               stat;
	logic [rae_pkg::WORD_WIDTH-1:0]  rd_value;
	logic [rae_pkg::WORD_WIDTH-1:0]  excess;
	logic                            ovf;
	logic                            unf;

	logic                            take;
	logic                            slot_free;
	logic                            present;
	logic                            known;
	logic                            report;

	// The program word for the current step drives everything below
	assign cw      = rae_pkg::ucode(upc_q);
	assign upc_inc = upc_q + 1'b1;

	// Accept only in the idle step; results wait in the output register
	assign in_stall  = (upc_q != rae_pkg::U_IDLE);
	assign take      = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign report    = (cw.dp == rae_pkg::DP_REPORT) && slot_free;

	assign present = ({1'b0, tgt_q} < (rae_pkg::TGT_W + 1)'(rae_pkg::REG_COUNT));
	assign known   = (cmd_q >= rae_pkg::OP_SET) && (cmd_q <= rae_pkg::OP_DVI);

	// Opcode dispatch: halt first, then unknown opcodes, then missing registers
	always_comb begin
		priority if (halted_q) begin
			disp_addr = rae_pkg::U_NOP;
		end else if (!known) begin
			disp_addr = rae_pkg::U_FAULT;
		end else if (!present) begin
			disp_addr = rae_pkg::U_NOP;
		end else if (cmd_q == rae_pkg::OP_SET) begin
			disp_addr = rae_pkg::U_SET;
		end else if (cmd_q == rae_pkg::OP_ADD) begin
			disp_addr = rae_pkg::U_ADD;
		end else if (cmd_q == rae_pkg::OP_SUB) begin
			disp_addr = rae_pkg::U_SUB;
		end else if (cmd_q == rae_pkg::OP_MUL) begin
			disp_addr = rae_pkg::U_MUL;
		end else if (cmd_q == rae_pkg::OP_DIV) begin
			disp_addr = rae_pkg::U_DIV_INI;
		end else begin
			// MLI and DVI do nothing
			disp_addr = rae_pkg::U_NOP;
		end
	end

	// Next step
	always_comb begin
		unique case (cw.jmp)
			rae_pkg::J_NEXT:     upc_d = upc_inc;
			rae_pkg::J_GOTO:     upc_d = cw.tgt;
			rae_pkg::J_ACCEPT:   upc_d = take ? cw.tgt : upc_q;
			rae_pkg::J_DISPATCH: upc_d = disp_addr;
			rae_pkg::J_IF_ZERO:  upc_d = stat.opnd_zero ? cw.tgt : upc_inc;
			rae_pkg::J_LOOP:     upc_d = stat.div_last ? upc_inc : cw.tgt;
			rae_pkg::J_REPORT:   upc_d = slot_free ? cw.tgt : upc_q;
			default:             upc_d = rae_pkg::U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q    <= rae_pkg::U_IDLE;
			halted_q <= 1'b0;
			fault_q  <= 1'b0;
		end else begin
			upc_q <= upc_d;
			// fault belongs to one item: clear on accept, set on the fault step
			if (take) begin
				fault_q <= 1'b0;
			end else if (cw.dp == rae_pkg::DP_FAULT) begin
				fault_q  <= 1'b1;
				halted_q <= 1'b1;
			end
		end
	end

	// Capture the instruction
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q  <= command;
			tgt_q  <= target_register;
			opnd_q <= operand_value;
		end
	end

	rae_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.dp       (cw.dp),
		.tgt      (tgt_q),
		.opnd     (opnd_q),
		.stat     (stat),
		.rd_value (rd_value),
		.excess   (excess),
		.ovf      (ovf),
		.unf      (unf)
	);

	// Output register: load on report, drop when taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			out_tgt_q    <= tgt_q;
			out_reg_q    <= present ? rd_value : '0;
			out_exc_q    <= excess;
			out_ovf_q    <= ovf;
			out_unf_q    <= unf;
			out_fault_q  <= fault_q;
			out_halted_q <= halted_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign written_register = out_tgt_q;
	assign register_value   = out_reg_q;
	assign excess_value     = out_exc_q;
	assign overflow_flag    = out_ovf_q;
	assign underflow_flag   = out_unf_q;
	assign fault            = out_fault_q;
	assign halted           = out_halted_q;

endmodule

`default_nettype wire

// ----- design/rae_datapath.sv -----
// ----------------------------------------------------------------------------
// rae_datapath: register file, excess word, flags and arithmetic units
// Carries out one microcode action per cycle; the divider runs one
// quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [rae_pkg::DP_W-1:0]           dp,
	input  wire logic [rae_pkg::TGT_W-1:0]          tgt,
	input  wire logic [rae_pkg::WORD_WIDTH-1:0]     opnd,
	output rae_pkg::dp_stat_t                       stat,
	output logic      [rae_pkg::WORD_WIDTH-1:0]     rd_value,
	output logic      [rae_pkg::WORD_WIDTH-1:0]     excess,
	output logic                                    ovf,
	output logic                                    unf
);

	localparam int W = rae_pkg::WORD_WIDTH;

	logic [W-1:0]                    rf_q [rae_pkg::REG_COUNT];
	logic [W-1:0]                    excess_q;
	logic                            ovf_q;
	logic                            unf_q;
	logic [2*W-1:0]                  prod_q;
	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    quo_q;
	logic [rae_pkg::DIV_CNT_W-1:0]   cnt_q;

	logic [rae_pkg::RF_IDX_W-1:0]    idx;
	logic [W-1:0]                    r;
	logic [W:0]                      sum;
	logic                            borrow;
	logic [W:0]                      shifted;
	logic [W:0]                      trial;
	logic                            fits;

	assign idx     = tgt[rae_pkg::RF_IDX_W-1:0];
	assign r       = rf_q[idx];
	assign sum     = {1'b0, r} + {1'b0, opnd};
	assign borrow  = opnd > r;
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, opnd};
	assign fits    = !trial[W];

	assign stat.div_last  = (cnt_q == rae_pkg::DIV_CNT_W'(W - 1));
	assign stat.opnd_zero = (opnd == '0);

	assign rd_value = r;
	assign excess   = excess_q;
	assign ovf      = ovf_q;
	assign unf      = unf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rae_pkg::REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
			excess_q <= '0;
			ovf_q    <= 1'b0;
			unf_q    <= 1'b0;
		end else begin
			unique case (dp)
				rae_pkg::DP_SET: begin
					rf_q[idx] <= opnd;
				end
				rae_pkg::DP_ADD: begin
					if (sum[W]) begin
						rf_q[idx] <= '0;
						excess_q  <= W'(1);
						ovf_q     <= 1'b1;
					end else begin
						rf_q[idx] <= sum[W-1:0];
						excess_q  <= '0;
					end
				end
				rae_pkg::DP_SUB: begin
					if (borrow) begin
						rf_q[idx] <= '0;
						excess_q  <= '1;
						unf_q     <= 1'b1;
					end else begin
						rf_q[idx] <= r - opnd;
						excess_q  <= '0;
					end
				end
				rae_pkg::DP_MUL_WB: begin
					rf_q[idx] <= prod_q[W-1:0];
					excess_q  <= prod_q[2*W-1:W];
				end
				rae_pkg::DP_DIV_INI: begin
					// divide by zero clears both words and ends here
					if (stat.opnd_zero) begin
						rf_q[idx] <= '0;
						excess_q  <= '0;
					end
				end
				rae_pkg::DP_DIV_WB: begin
					rf_q[idx] <= quo_q;
					excess_q  <= quo_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Multiplier product and divider working registers
	always_ff @(posedge clk) begin
		unique case (dp)
			rae_pkg::DP_MUL: begin
				prod_q <= r * opnd;
			end
			rae_pkg::DP_DIV_INI: begin
				rem_q <= '0;
				quo_q <= r;
				cnt_q <= '0;
			end
			rae_pkg::DP_DIV_STP: begin
				rem_q <= fits ? trial[W-1:0] : shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
